### hw/rtl/wcr_pkg.sv
// Shared types and constants of the wind component resolver.
package wcr_pkg;

	localparam int ANGLE_W = 20;
	localparam int SPEED_W = 16;
	localparam int COMP_W = 17;
	localparam int DRIFT_W = 15;

	localparam int FULL_TURN = 23040;
	localparam int HALF_TURN = 11520;
	localparam int QUARTER_TURN = 5760;

	localparam int WRAP_W = ANGLE_W + 2;
	localparam logic [WRAP_W-1:0] WRAP_OFFSET = WRAP_W'(46 * FULL_TURN);
	localparam int LOW_BITS = 9;
	localparam int HIGH_W = WRAP_W - LOW_BITS;
	localparam int TURN_HIGH = FULL_TURN / (1 << LOW_BITS);
	localparam int RECIP_SHIFT = 19;
	localparam int RECIP_W = 14;
	localparam logic [RECIP_W-1:0] RECIP_TURN_HIGH =
		RECIP_W'(((1 << RECIP_SHIFT) + TURN_HIGH - 1) / TURN_HIGH);
	localparam int RPROD_W = HIGH_W + RECIP_W;
	localparam int QUOT_W = RPROD_W - RECIP_SHIFT;

	localparam int FRAC_BITS = 14;
	localparam int XY_W = SPEED_W + FRAC_BITS + 3;
	localparam int Z_W = DRIFT_W + 16;
	localparam int MAG_W = 32;
	localparam int GAIN_W = 30;
	localparam logic [GAIN_W-1:0] GAIN_INV = GAIN_W'(652032874);
	localparam int PROD_W = MAG_W + GAIN_W;
	localparam int ROUND_SHIFT = GAIN_W + FRAC_BITS;
	localparam int RMAG_W = PROD_W - ROUND_SHIFT;
	localparam logic [RMAG_W-1:0] COMP_MAX = RMAG_W'(65535);

	localparam int ATAN_ENTRIES = 24;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic [SPEED_W-1:0] speed_t;
	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic signed [DRIFT_W-1:0] drift_t;
	typedef logic signed [XY_W-1:0] xy_t;
	typedef logic signed [Z_W-1:0] z_t;

	typedef struct packed {
		logic   flip;
		speed_t speed;
		drift_t drift;
	} side_t;

	localparam z_t ATAN_TAB [0:ATAN_ENTRIES-1] = '{
		z_t'(188743680), z_t'(111421900), z_t'(58872272), z_t'(29884485),
		z_t'(15000234), z_t'(7507429), z_t'(3754631), z_t'(1877430),
		z_t'(938729), z_t'(469366), z_t'(234683), z_t'(117342),
		z_t'(58671), z_t'(29335), z_t'(14668), z_t'(7334),
		z_t'(3667), z_t'(1833), z_t'(917), z_t'(458),
		z_t'(229), z_t'(115), z_t'(57), z_t'(29)
	};

endpackage

### hw/rtl/wcr_sample_if.sv
// Input channel: three angles and a wind speed with valid/ready.
interface wcr_sample_if;
	import wcr_pkg::*;

	logic   valid;
	logic   ready;
	angle_t track_angle;
	angle_t heading_angle;
	angle_t wind_from_angle;
	speed_t speed;

	modport source (
		output valid, track_angle, heading_angle, wind_from_angle, speed,
		input  ready
	);
	modport sink (
		input  valid, track_angle, heading_angle, wind_from_angle, speed,
		output ready
	);
endinterface

### hw/rtl/wcr_result_if.sv
// Output channel: wind components, speed and drift with valid/ready.
interface wcr_result_if;
	import wcr_pkg::*;

	logic   valid;
	logic   ready;
	comp_t  headwind;
	comp_t  crosswind;
	speed_t wind_mag;
	drift_t drift_angle;

	modport source (
		output valid, headwind, crosswind, wind_mag, drift_angle,
		input  ready
	);
	modport sink (
		input  valid, headwind, crosswind, wind_mag, drift_angle,
		output ready
	);
endinterface

### hw/rtl/wcr_cordic.sv
// Pipelined CORDIC rotation with gain correction, rounding and saturation.
module wcr_cordic #(
	parameter int STAGES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           in_valid,
	input  wcr_pkg::xy_t   in_x,
	input  wcr_pkg::z_t    in_z,
	input  wcr_pkg::side_t in_side,
	output logic           out_valid,
	output wcr_pkg::comp_t out_head,
	output wcr_pkg::comp_t out_cross,
	output wcr_pkg::side_t out_side
);
	import wcr_pkg::*;

	localparam int NSTG = (STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : STAGES;

	logic  v_s    [0:NSTG-1];
	xy_t   x_s    [0:NSTG-1];
	xy_t   y_s    [0:NSTG-1];
	z_t    z_s    [0:NSTG-1];
	side_t side_s [0:NSTG-1];

	for (genvar gi = 0; gi < NSTG; gi++) begin : g_stage
		logic  vp;
		xy_t   xp;
		xy_t   yp;
		z_t    zp;
		side_t sp;

		if (gi == 0) begin : g_first
			assign vp = in_valid;
			assign xp = in_x;
			assign yp = '0;
			assign zp = in_z;
			assign sp = in_side;
		end else begin : g_next
			assign vp = v_s[gi-1];
			assign xp = x_s[gi-1];
			assign yp = y_s[gi-1];
			assign zp = z_s[gi-1];
			assign sp = side_s[gi-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[gi] <= 1'b0;
			end else if (advance) begin
				v_s[gi] <= vp;
			end
		end

		// rotate towards zero residual angle
		always_ff @(posedge clk) begin
			if (advance) begin
				side_s[gi] <= sp;
				if (!zp[Z_W-1]) begin
					x_s[gi] <= xp - (yp >>> gi);
					y_s[gi] <= yp + (xp >>> gi);
					z_s[gi] <= zp - ATAN_TAB[gi];
				end else begin
					x_s[gi] <= xp + (yp >>> gi);
					y_s[gi] <= yp - (xp >>> gi);
					z_s[gi] <= zp + ATAN_TAB[gi];
				end
			end
		end
	end

	logic              v_s1, v_s2, v_s3;
	side_t             side_s1, side_s2, side_s3;
	logic              nx_s1, ny_s1, nx_s2, ny_s2;
	logic [MAG_W-1:0]  mx_s1, my_s1;
	logic [PROD_W-1:0] px_s2, py_s2;
	comp_t             head_s3, cross_s3;
	xy_t               xf;
	xy_t               yf;
	xy_t               xa;
	xy_t               ya;
	logic [PROD_W-1:0] rx_sum, ry_sum;
	logic [RMAG_W-1:0] rx, ry;
	logic [RMAG_W-1:0] sx, sy;

	assign xf = x_s[NSTG-1];
	assign yf = y_s[NSTG-1];
	assign xa = xf[XY_W-1] ? -xf : xf;
	assign ya = yf[XY_W-1] ? -yf : yf;

	assign rx_sum = px_s2 + (PROD_W'(1) << (ROUND_SHIFT - 1));
	assign ry_sum = py_s2 + (PROD_W'(1) << (ROUND_SHIFT - 1));
	assign rx = rx_sum[PROD_W-1:ROUND_SHIFT];
	assign ry = ry_sum[PROD_W-1:ROUND_SHIFT];
	assign sx = (rx > COMP_MAX) ? COMP_MAX : rx;
	assign sy = (ry > COMP_MAX) ? COMP_MAX : ry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= v_s[NSTG-1];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_s1  <= side_s[NSTG-1];
			nx_s1    <= xf[XY_W-1];
			ny_s1    <= yf[XY_W-1];
			mx_s1    <= xa[MAG_W-1:0];
			my_s1    <= ya[MAG_W-1:0];

			side_s2  <= side_s1;
			nx_s2    <= nx_s1;
			ny_s2    <= ny_s1;
			px_s2    <= PROD_W'(mx_s1) * PROD_W'(GAIN_INV);
			py_s2    <= PROD_W'(my_s1) * PROD_W'(GAIN_INV);

			side_s3  <= side_s2;
			head_s3  <= (nx_s2 ^ side_s2.flip) ? -comp_t'({1'b0, sx[SPEED_W-1:0]})
				: comp_t'({1'b0, sx[SPEED_W-1:0]});
			cross_s3 <= (ny_s2 ^ side_s2.flip) ? -comp_t'({1'b0, sy[SPEED_W-1:0]})
				: comp_t'({1'b0, sy[SPEED_W-1:0]});
		end
	end

	assign out_valid = v_s3;
	assign out_head  = head_s3;
	assign out_cross = cross_s3;
	assign out_side  = side_s3;

endmodule

### hw/rtl/wind_component_resolver_top.sv
// Top level of the wind component resolver: angle folding, CORDIC and output buffer.
// Pipeline: four angle stages, one per CORDIC iteration, three for gain and rounding,
//   and the output register, passed in that order by each accepted transaction.
// Throughput: one transaction per cycle; a two-entry output buffer takes the stall,
//   and the whole pipeline holds while its second entry is full.
// Reset: arst_n clears every valid flag and the output buffer; data registers keep value.
module wind_component_resolver_top #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	wcr_sample_if.sink   sample,
	wcr_result_if.source result
);
	import wcr_pkg::*;

	logic advance;

	logic              v_s1, v_s2, v_s3, v_s4;
	logic [WRAP_W-1:0] du_s1, ru_s1, du_s2, ru_s2;
	logic [QUOT_W-1:0] dq_s2, rq_s2;
	speed_t            spd_s1, spd_s2, spd_s3;
	drift_t            drift_s3, rel_s3;
	xy_t               x_s4;
	z_t                z_s4;
	side_t             side_s4;

	logic signed [ANGLE_W:0] drift_d, rel_d;
	logic [RPROD_W-1:0]      dq_prod, rq_prod;
	logic                    flip;
	drift_t                  rel_adj;

	logic   c_valid;
	comp_t  c_head, c_cross;
	side_t  c_side;
	logic   take;

	logic   out_v_q, skid_v_q;
	comp_t  out_head_q, out_cross_q, skid_head_q, skid_cross_q;
	speed_t out_spd_q, skid_spd_q;
	drift_t out_drift_q, skid_drift_q;

	function automatic drift_t fold_half(input logic [WRAP_W-1:0] u,
			input logic [QUOT_W-1:0] q);
		logic [HIGH_W-1:0] hi;
		logic [15:0]       w;
		logic [15:0]       f;
		hi = u[WRAP_W-1:LOW_BITS] - HIGH_W'(HIGH_W'(q) * HIGH_W'(TURN_HIGH));
		w = {1'b0, hi[5:0], u[LOW_BITS-1:0]};
		f = (w > 16'(HALF_TURN)) ? w - 16'(FULL_TURN) : w;
		return drift_t'(f[DRIFT_W-1:0]);
	endfunction

	assign advance = !skid_v_q;
	assign sample.ready = advance;

	assign drift_d = (ANGLE_W+1)'(sample.track_angle) - (ANGLE_W+1)'(sample.heading_angle);
	assign rel_d = (ANGLE_W+1)'(sample.wind_from_angle) - (ANGLE_W+1)'(sample.track_angle);

	assign dq_prod = RPROD_W'(du_s1[WRAP_W-1:LOW_BITS]) * RPROD_W'(RECIP_TURN_HIGH);
	assign rq_prod = RPROD_W'(ru_s1[WRAP_W-1:LOW_BITS]) * RPROD_W'(RECIP_TURN_HIGH);

	// bring the relative angle within a quarter turn
	always_comb begin
		flip = 1'b0;
		rel_adj = rel_s3;
		if (rel_s3 > drift_t'(QUARTER_TURN)) begin
			flip = 1'b1;
			rel_adj = rel_s3 - drift_t'(HALF_TURN);
		end else if (rel_s3 < drift_t'(-QUARTER_TURN)) begin
			flip = 1'b1;
			rel_adj = rel_s3 + drift_t'(HALF_TURN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			du_s1    <= WRAP_W'(drift_d) + WRAP_OFFSET;
			ru_s1    <= WRAP_W'(rel_d) + WRAP_OFFSET;
			spd_s1   <= sample.speed;

			du_s2    <= du_s1;
			ru_s2    <= ru_s1;
			dq_s2    <= dq_prod[RPROD_W-1:RECIP_SHIFT];
			rq_s2    <= rq_prod[RPROD_W-1:RECIP_SHIFT];
			spd_s2   <= spd_s1;

			drift_s3 <= fold_half(du_s2, dq_s2);
			rel_s3   <= fold_half(ru_s2, rq_s2);
			spd_s3   <= spd_s2;

			x_s4     <= xy_t'({3'b000, spd_s3, {FRAC_BITS{1'b0}}});
			z_s4     <= z_t'({rel_adj, 16'h0000});
			side_s4  <= '{flip: flip, speed: spd_s3, drift: drift_s3};
		end
	end

	wcr_cordic #(
		.STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_valid (v_s4),
		.in_x     (x_s4),
		.in_z     (z_s4),
		.in_side  (side_s4),
		.out_valid(c_valid),
		.out_head (c_head),
		.out_cross(c_cross),
		.out_side (c_side)
	);

	assign take = advance && c_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || result.ready) begin
			out_v_q  <= skid_v_q || take;
			skid_v_q <= 1'b0;
		end else if (take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || result.ready) begin
			if (skid_v_q) begin
				out_head_q  <= skid_head_q;
				out_cross_q <= skid_cross_q;
				out_spd_q   <= skid_spd_q;
				out_drift_q <= skid_drift_q;
			end else begin
				out_head_q  <= c_head;
				out_cross_q <= c_cross;
				out_spd_q   <= c_side.speed;
				out_drift_q <= c_side.drift;
			end
		end else if (take) begin
			skid_head_q  <= c_head;
			skid_cross_q <= c_cross;
			skid_spd_q   <= c_side.speed;
			skid_drift_q <= c_side.drift;
		end
	end

	assign result.valid       = out_v_q;
	assign result.headwind    = out_head_q;
	assign result.crosswind   = out_cross_q;
	assign result.wind_mag    = out_spd_q;
	assign result.drift_angle = out_drift_q;

`ifndef ASSERT_OFF
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("output buffer second entry full while first is empty");

	a_skid_from_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !result.ready))
		else $error("output buffer filled without a stalled transaction");

	a_calm_wind: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.wind_mag == '0
			|-> result.headwind == '0 && result.crosswind == '0)
		else $error("non-zero component for calm wind");

	a_drift_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.drift_angle > drift_t'(-HALF_TURN))
		else $error("drift angle outside half turn");
`endif

endmodule

### sim/wind_component_resolver_top_test.sv
// Self-checking testbench for the wind component resolver: directed table, then random traffic.
`timescale 1ns / 100ps

module wind_component_resolver_top_test;
	import wcr_pkg::angle_t;
	import wcr_pkg::speed_t;
	import wcr_pkg::comp_t;
	import wcr_pkg::drift_t;

	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_SAMPLES = 1680;
	localparam int QUIET_TAIL = 200;

	localparam int CIRCLE = 23040;
	localparam int SEMI_CIRCLE = 11520;
	localparam int QUARTER_CIRCLE = 5760;
	localparam int XY_FRAC = 14;
	localparam longint GAIN_CORR = 652032874;
	localparam int GAIN_FRAC = 30;
	localparam longint COMPONENT_MAX = 65535;
	localparam int ARCTAN_COUNT = 24;
	localparam longint ARCTAN [0:ARCTAN_COUNT-1] = '{
		188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
		3754631, 1877430, 938729, 469366, 234683, 117342,
		58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29
	};

	typedef struct packed {
		comp_t  headwind;
		comp_t  crosswind;
		speed_t wind_mag;
		drift_t drift_angle;
	} wind_result_t;

	typedef struct packed {
		angle_t track;
		angle_t heading;
		angle_t wind_from;
		speed_t speed;
		logic   known;
		comp_t  headwind;
		comp_t  crosswind;
		drift_t drift;
	} wind_row_t;

	localparam int ROW_COUNT = 22;
	localparam wind_row_t DIRECTED_ROWS [0:ROW_COUNT-1] = '{
		'{angle_t'(0), angle_t'(0), angle_t'(0), speed_t'(0),
			1'b1, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(11520), angle_t'(0), angle_t'(0), speed_t'(0),
			1'b1, comp_t'(0), comp_t'(0), drift_t'(11520)},
		'{angle_t'(0), angle_t'(11520), angle_t'(0), speed_t'(0),
			1'b1, comp_t'(0), comp_t'(0), drift_t'(11520)},
		'{angle_t'(0), angle_t'(11519), angle_t'(0), speed_t'(0),
			1'b1, comp_t'(0), comp_t'(0), drift_t'(-11519)},
		'{angle_t'(23040), angle_t'(0), angle_t'(0), speed_t'(0),
			1'b1, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(0), angle_t'(0), angle_t'(0), speed_t'(65535),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(0), angle_t'(0), angle_t'(11520), speed_t'(65535),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(0), angle_t'(0), angle_t'(5760), speed_t'(65535),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(0), angle_t'(0), angle_t'(-5760), speed_t'(65535),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(0), angle_t'(0), angle_t'(5761), speed_t'(1000),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(0), angle_t'(0), angle_t'(-5761), speed_t'(1000),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(0), angle_t'(0), angle_t'(2880), speed_t'(65535),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(-524288), angle_t'(-524288), angle_t'(-524288), speed_t'(65535),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(524287), angle_t'(524287), angle_t'(524287), speed_t'(65535),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(524287), angle_t'(-524288), angle_t'(0), speed_t'(32768),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(-524288), angle_t'(524287), angle_t'(524287), speed_t'(1),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(230500), angle_t'(-1000), angle_t'(240000), speed_t'(12345),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(-100000), angle_t'(100000), angle_t'(-300000), speed_t'(4660),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(0), angle_t'(0), angle_t'(0), speed_t'(1),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(5000), angle_t'(-5000), angle_t'(11519), speed_t'(65535),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(0), angle_t'(0), angle_t'(-11519), speed_t'(65535),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)},
		'{angle_t'(0), angle_t'(0), angle_t'(17280), speed_t'(300),
			1'b0, comp_t'(0), comp_t'(0), drift_t'(0)}
	};

	logic clk = 1'b0;
	logic arst_n;

	wcr_sample_if sample_bus ();
	wcr_result_if result_bus ();

	wind_component_resolver_top #(
		.CORDIC_STAGES(STAGES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_bus),
		.result (result_bus)
	);

	wind_result_t expected_winds [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int idle_pct = 25;
	int ready_hold = 0;

	always #5 clk = ~clk;

	function automatic int wrap_circle(int a);
		int r;
		r = a % CIRCLE;
		if (r < 0) begin
			r += CIRCLE;
		end
		return r;
	endfunction

	function automatic int fold_circle(int a);
		int r;
		r = wrap_circle(a);
		if (r > SEMI_CIRCLE) begin
			r -= CIRCLE;
		end
		return r;
	endfunction

	function automatic longint scale_component(longint v);
		longint m;
		logic neg;
		neg = v < 0;
		m = neg ? -v : v;
		m = m * GAIN_CORR;
		m = (m + (longint'(1) <<< (GAIN_FRAC + XY_FRAC - 1))) >>> (GAIN_FRAC + XY_FRAC);
		if (m > COMPONENT_MAX) begin
			m = COMPONENT_MAX;
		end
		return neg ? -m : m;
	endfunction

	function automatic wind_result_t resolve_wind(angle_t trk_in, angle_t hdg_in,
		angle_t wfr_in, speed_t spd);
		wind_result_t res;
		int trk, hdg, wfr, drift, rel, i;
		logic flip;
		longint x, y, z, dx, dy, c, s;
		trk = wrap_circle(int'(trk_in));
		hdg = wrap_circle(int'(hdg_in));
		wfr = wrap_circle(int'(wfr_in));
		drift = fold_circle(trk - hdg);
		rel = fold_circle(wfr - trk);
		flip = 1'b0;
		if (rel > QUARTER_CIRCLE) begin
			rel -= SEMI_CIRCLE;
			flip = 1'b1;
		end else if (rel < -QUARTER_CIRCLE) begin
			rel += SEMI_CIRCLE;
			flip = 1'b1;
		end
		x = longint'(spd) <<< XY_FRAC;
		y = 0;
		z = longint'(rel) * 65536;
		for (i = 0; i < STAGES && i < ARCTAN_COUNT; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ARCTAN[i];
			end else begin
				x += dx;
				y -= dy;
				z += ARCTAN[i];
			end
		end
		c = scale_component(x);
		s = scale_component(y);
		if (flip) begin
			c = -c;
			s = -s;
		end
		res.headwind = comp_t'(c);
		res.crosswind = comp_t'(s);
		res.wind_mag = spd;
		res.drift_angle = drift_t'(drift);
		return res;
	endfunction

	function automatic int near_boundary();
		int pick, offset;
		pick = int'($urandom_range(0, 4));
		case (pick)
			0: offset = 0;
			1: offset = QUARTER_CIRCLE;
			2: offset = -QUARTER_CIRCLE;
			3: offset = SEMI_CIRCLE;
			default: offset = -SEMI_CIRCLE;
		endcase
		return offset + int'($urandom_range(0, 6)) - 3 + CIRCLE * (int'($urandom_range(0, 8)) - 4);
	endfunction

	task automatic pick_random_sample(output angle_t trk, output angle_t hdg,
		output angle_t wfr, output speed_t spd);
		int base;
		base = int'($urandom_range(0, 400000)) - 200000;
		case ($urandom_range(0, 3))
			0, 1: begin
				trk = angle_t'($urandom);
				hdg = angle_t'($urandom);
				wfr = angle_t'($urandom);
			end
			2: begin
				trk = angle_t'(base);
				hdg = angle_t'($urandom);
				wfr = angle_t'(base + near_boundary());
			end
			default: begin
				trk = angle_t'(base);
				hdg = angle_t'(base + near_boundary());
				wfr = angle_t'($urandom);
			end
		endcase
		case ($urandom_range(0, 7))
			0: spd = speed_t'(0);
			1: spd = speed_t'(16'hffff);
			2: spd = speed_t'($urandom_range(0, 15));
			default: spd = speed_t'($urandom);
		endcase
	endtask

	task automatic send_sample(angle_t trk, angle_t hdg, angle_t wfr, speed_t spd,
		logic known, wind_result_t typed);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			sample_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.track_angle <= trk;
		sample_bus.heading_angle <= hdg;
		sample_bus.wind_from_angle <= wfr;
		sample_bus.speed <= spd;
		do @(posedge clk); while (!sample_bus.ready);
		if (known) begin
			expected_winds.push_back(typed);
		end else begin
			expected_winds.push_back(resolve_wind(trk, hdg, wfr, spd));
		end
	endtask

	task automatic drain_results();
		sample_bus.valid <= 1'b0;
		while (expected_winds.size() != 0) @(posedge clk);
	endtask

	task automatic check_result();
		wind_result_t want;
		if (expected_winds.size() == 0) begin
			$error("result transaction with no expectation pending");
			mismatch_count++;
		end else begin
			want = expected_winds.pop_front();
			if (result_bus.headwind !== want.headwind) begin
				$error("headwind expected %0d got %0d", want.headwind, result_bus.headwind);
				mismatch_count++;
			end
			if (result_bus.crosswind !== want.crosswind) begin
				$error("crosswind expected %0d got %0d", want.crosswind, result_bus.crosswind);
				mismatch_count++;
			end
			if (result_bus.wind_mag !== want.wind_mag) begin
				$error("wind_mag expected %0d got %0d", want.wind_mag,
					result_bus.wind_mag);
				mismatch_count++;
			end
			if (result_bus.drift_angle !== want.drift_angle) begin
				$error("drift_angle expected %0d got %0d", want.drift_angle,
					result_bus.drift_angle);
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			check_result();
		end
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
			result_bus.ready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			ready_hold <= $urandom_range(0, 2);
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		wind_row_t row;
		wind_result_t typed;
		angle_t trk, hdg, wfr;
		speed_t spd;
		int n;
		arst_n <= 1'b0;
		sample_bus.valid <= 1'b0;
		sample_bus.track_angle <= '0;
		sample_bus.heading_angle <= '0;
		sample_bus.wind_from_angle <= '0;
		sample_bus.speed <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < ROW_COUNT; n++) begin
			row = DIRECTED_ROWS[n];
			typed.headwind = row.headwind;
			typed.crosswind = row.crosswind;
			typed.wind_mag = row.speed;
			typed.drift_angle = row.drift;
			send_sample(row.track, row.heading, row.wind_from, row.speed, row.known, typed);
		end
		drain_results();

		typed = '0;
		for (n = 0; n < RANDOM_SAMPLES; n++) begin
			if (n >= RANDOM_SAMPLES - QUIET_TAIL) begin
				idle_pct = 0;
			end else if (n % 128 == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 20;
					default: idle_pct = 40;
				endcase
			end
			if (n == 800 || $urandom_range(0, 299) == 0) begin
				drain_results();
			end
			pick_random_sample(trk, hdg, wfr, spd);
			send_sample(trk, hdg, wfr, spd, 1'b0, typed);
		end
		drain_results();
		repeat (4 * LATENCY) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/wcr_pkg.sv
hw/rtl/wcr_sample_if.sv
hw/rtl/wcr_result_if.sv
hw/rtl/wcr_cordic.sv
hw/rtl/wind_component_resolver_top.sv
sim/wind_component_resolver_top_test.sv
